>>> design/ray_triangle_intersection_macros.svh
// assertion helpers for the ray/triangle test
`ifndef RAY_TRIANGLE_INTERSECTION_MACROS_SVH
`define RAY_TRIANGLE_INTERSECTION_MACROS_SVH

`ifndef SYNTH
`define RTI_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define RTI_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define RTI_ASSERT_IMPL(lbl, ante, cons)
`define RTI_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

>>> design/rti_pkg.sv
package rti_pkg;

    localparam int T_FRAC       = 16;
    localparam int T_INT        = 32;
    localparam int QUO_BITS     = T_INT + T_FRAC;
    localparam int EPS_BITS     = 31;
    localparam int CFG_IDX_BITS = 3;
    localparam int EPS_RESET    = 66;
    localparam int ONE_Q8_8     = 256;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_ORIGIN_X = 3'd0,
        CFG_ORIGIN_Y = 3'd1,
        CFG_ORIGIN_Z = 3'd2,
        CFG_DIR_X    = 3'd3,
        CFG_DIR_Y    = 3'd4,
        CFG_DIR_Z    = 3'd5,
        CFG_EPSILON  = 3'd6
    } t_cfg_idx;

endpackage

>>> design/rti_div.sv
module rti_div #(
    parameter int DW = 53
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_ce,
    input  logic                         i_valid,
    input  logic                         i_ok,
    input  logic [DW-1:0]                i_num,
    input  logic [DW-1:0]                i_den,
    output logic                         o_valid,
    output logic                         o_ok,
    output logic                         o_big,
    output logic [rti_pkg::QUO_BITS-1:0] o_quo
);
    import rti_pkg::*;

    localparam int UW = DW + T_INT;
    localparam int QB = QUO_BITS;

    logic [UW-1:0] w_num_ext;
    logic [DW-1:0] w_rem0;

    logic [DW-1:0] r_rem  [QB];
    logic [QB-1:0] r_bits [QB];
    logic [DW-1:0] r_den  [QB];
    logic [QB-1:0] r_quo  [1:QB];
    logic          r_vld  [QB+1];
    logic          r_ok   [QB+1];
    logic          r_big  [QB+1];

    assign w_num_ext = {{T_INT{1'b0}}, i_num};
    assign w_rem0    = DW'(w_num_ext >> T_INT);

    // entry: top bits of the dividend form the first partial remainder
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else if (i_ce) begin
            r_vld[0] <= i_valid;
        end
        if (i_ce) begin
            r_rem[0]  <= w_rem0;
            r_bits[0] <= {w_num_ext[T_INT-1:0], {T_FRAC{1'b0}}};
            r_den[0]  <= i_den;
            r_ok[0]   <= i_ok;
            r_big[0]  <= (w_rem0 >= i_den);
        end
    end

    // one quotient bit per stage
    for (genvar k = 1; k <= QB; k++) begin : g_stage
        logic [DW:0] w_trial;
        logic        w_ge;

        assign w_trial = {r_rem[k-1], r_bits[k-1][QB-1]};
        assign w_ge    = (w_trial >= {1'b0, r_den[k-1]});

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (i_ce) begin
                r_vld[k] <= r_vld[k-1];
            end
            if (i_ce) begin
                r_ok[k]  <= r_ok[k-1];
                r_big[k] <= r_big[k-1];
            end
        end

        if (k == 1) begin : g_first
            always_ff @(posedge i_clk) begin
                if (i_ce) begin
                    r_quo[k] <= QB'(w_ge);
                end
            end
        end else begin : g_next
            always_ff @(posedge i_clk) begin
                if (i_ce) begin
                    r_quo[k] <= {r_quo[k-1][QB-2:0], w_ge};
                end
            end
        end

        if (k < QB) begin : g_mid
            always_ff @(posedge i_clk) begin
                if (i_ce) begin
                    r_rem[k]  <= w_ge ? DW'(w_trial - {1'b0, r_den[k-1]}) : DW'(w_trial);
                    r_bits[k] <= r_bits[k-1] << 1;
                    r_den[k]  <= r_den[k-1];
                end
            end
        end
    end

    assign o_valid = r_vld[QB];
    assign o_ok    = r_ok[QB];
    assign o_big   = r_big[QB];
    assign o_quo   = r_quo[QB];

endmodule

>>> design/ray_triangle_intersection.sv
// Tests one ray, held in the configuration registers, against a stream of triangles and
// returns one result beat for every triangle beat, in order. The datapath is a fully
// pipelined Cramer's-rule solver followed by a restoring divider with one quotient bit per
// stage, so a new triangle is taken every cycle unless the result side stalls; the pipeline
// holds 9 arithmetic stages plus 48 divider stages and its entry register (default widths).
// A stall on the result side freezes the whole pipeline. The user must write ray registers
// only while no triangle is in flight; the block itself does not enforce this.
module ray_triangle_intersection #(
    parameter int COORD_BITS  = 16,
    parameter int RESULT_BITS = 32
) (
    input  logic                                        i_clk,
    input  logic                                        i_rst_n,
    input  logic                                        i_cfg_we,
    input  logic [rti_pkg::CFG_IDX_BITS-1:0]            i_cfg_idx,
    input  logic [((COORD_BITS > rti_pkg::EPS_BITS) ? COORD_BITS
                   : rti_pkg::EPS_BITS)-1:0]            i_cfg_wdata,
    input  logic                                        i_s_tvalid,
    output logic                                        o_s_tready,
    // vert0_x, vert0_y, vert0_z, vert1_x .. vert2_z, zero pad
    input  logic [((9*COORD_BITS+7)/8)*8-1:0]           i_s_tdata,
    output logic                                        o_m_tvalid,
    input  logic                                        i_m_tready,
    // is_hit, t_hit, point_x, point_y, point_z, zero pad
    output logic [((1+4*RESULT_BITS+7)/8)*8-1:0]        o_m_tdata
);
    import rti_pkg::*;

    `include "ray_triangle_intersection_macros.svh"

    localparam int C     = COORD_BITS;
    localparam int R     = RESULT_BITS;
    localparam int DIF   = C + 1;
    localparam int MW    = 2*C + 3;
    localparam int PW    = DIF + MW;
    localparam int SW    = PW + 2;
    localparam int AW    = PW + 1;
    localparam int TW    = (QUO_BITS > R) ? QUO_BITS : R;
    localparam int PRW   = C + R + 1;
    localparam int SUMW  = C + R + 2;
    localparam int OUTW  = ((1+4*R+7)/8)*8;
    localparam logic [R-1:0] RMAX = {1'b0, {(R-1){1'b1}}};
    localparam logic signed [SUMW-1:0] SMAX = (SUMW'(1) <<< (R-1)) - SUMW'(1);
    localparam logic signed [SUMW-1:0] SMIN = -SMAX - SUMW'(1);

    logic signed [C-1:0]  r_orig [3];
    logic signed [C-1:0]  r_dir  [3];
    logic [EPS_BITS-1:0]  r_eps;

    logic w_ce;

    logic signed [C-1:0]   w_v [9];
    logic signed [DIF-1:0] w_d [3];

    logic                  r_v1;
    logic signed [DIF-1:0] r1_a [3];
    logic signed [DIF-1:0] r1_b [3];
    logic signed [DIF-1:0] r1_dd [3];

    logic                  r_v2;
    logic signed [DIF-1:0] r2_a0, r2_b0, r2_d0;
    logic signed [MW-1:0]  r2_m, r2_n, r2_p, r2_q, r2_s, r2_r;

    logic                  r_v3;
    logic signed [PW-1:0]  r3_p [12];

    logic                  r_v4;
    logic signed [SW-1:0]  r4_det, r4_e1, r4_e2, r4_e3;

    logic                  r_v5;
    logic signed [SW-1:0]  r5_det, r5_e1, r5_e2, r5_e3;

    logic                  r_v6;
    logic                  r6_ok;
    logic [AW-1:0]         r6_det, r6_e3;

    logic                  w_div_vld, w_div_ok, w_div_big;
    logic [QUO_BITS-1:0]   w_div_quo;

    logic                  r_v7;
    logic                  r7_hit;
    logic [R-1:0]          r7_tout;

    logic                  r_v8;
    logic                  r8_hit;
    logic [R-1:0]          r8_tout;
    logic signed [PRW-1:0] r8_prod [3];

    logic                  r_vo;
    logic                  r_hit;
    logic [R-1:0]          r_t;
    logic [R-1:0]          r_pt [3];
    logic [R-1:0]          n_pt [3];

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_orig[0] <= '0;
            r_orig[1] <= '0;
            r_orig[2] <= '0;
            r_dir[0]  <= '0;
            r_dir[1]  <= '0;
            r_dir[2]  <= C'(ONE_Q8_8);
            r_eps     <= EPS_BITS'(EPS_RESET);
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_ORIGIN_X: r_orig[0] <= i_cfg_wdata[C-1:0];
                CFG_ORIGIN_Y: r_orig[1] <= i_cfg_wdata[C-1:0];
                CFG_ORIGIN_Z: r_orig[2] <= i_cfg_wdata[C-1:0];
                CFG_DIR_X:    r_dir[0]  <= i_cfg_wdata[C-1:0];
                CFG_DIR_Y:    r_dir[1]  <= i_cfg_wdata[C-1:0];
                CFG_DIR_Z:    r_dir[2]  <= i_cfg_wdata[C-1:0];
                CFG_EPSILON:  r_eps     <= i_cfg_wdata[EPS_BITS-1:0];
                default: ;
            endcase
        end
    end

    assign w_ce       = !r_vo || i_m_tready;
    assign o_s_tready = w_ce;

    always_comb begin
        for (int k = 0; k < 9; k++) begin
            w_v[k] = i_s_tdata[k*C +: C];
        end
        for (int j = 0; j < 3; j++) begin
            w_d[j] = DIF'(r_dir[j]);
        end
    end

    // valid chain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
            r_v6 <= 1'b0;
            r_v7 <= 1'b0;
            r_v8 <= 1'b0;
            r_vo <= 1'b0;
        end else if (w_ce) begin
            r_v1 <= i_s_tvalid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            r_v5 <= r_v4;
            r_v6 <= r_v5;
            r_v7 <= w_div_vld;
            r_v8 <= r_v7;
            r_vo <= r_v8;
        end
    end

    // edge vectors and origin offset
    always_ff @(posedge i_clk) begin
        if (w_ce) begin
            for (int j = 0; j < 3; j++) begin
                r1_a[j]  <= DIF'(w_v[j]) - DIF'(w_v[3+j]);
                r1_b[j]  <= DIF'(w_v[j]) - DIF'(w_v[6+j]);
                r1_dd[j] <= DIF'(w_v[j]) - DIF'(r_orig[j]);
            end
        end
    end

    // 2x2 minors
    always_ff @(posedge i_clk) begin
        if (w_ce) begin
            r2_a0 <= r1_a[0];
            r2_b0 <= r1_b[0];
            r2_d0 <= r1_dd[0];
            r2_m  <= MW'(r1_b[1]) * MW'(w_d[2]) - MW'(w_d[1]) * MW'(r1_b[2]);
            r2_n  <= MW'(r1_dd[1]) * MW'(w_d[2]) - MW'(w_d[1]) * MW'(r1_dd[2]);
            r2_p  <= MW'(r1_b[1]) * MW'(r1_dd[2]) - MW'(r1_dd[1]) * MW'(r1_b[2]);
            r2_q  <= MW'(w_d[1]) * MW'(r1_a[2]) - MW'(r1_a[1]) * MW'(w_d[2]);
            r2_s  <= MW'(r1_a[1]) * MW'(r1_b[2]) - MW'(r1_b[1]) * MW'(r1_a[2]);
            r2_r  <= MW'(r1_a[1]) * MW'(r1_dd[2]) - MW'(r1_dd[1]) * MW'(r1_a[2]);
        end
    end

    // cofactor products
    always_ff @(posedge i_clk) begin
        if (w_ce) begin
            r3_p[0]  <= PW'(r2_a0) * PW'(r2_m);
            r3_p[1]  <= PW'(r2_b0) * PW'(r2_q);
            r3_p[2]  <= PW'(w_d[0]) * PW'(r2_s);
            r3_p[3]  <= PW'(r2_d0) * PW'(r2_m);
            r3_p[4]  <= PW'(r2_b0) * PW'(r2_n);
            r3_p[5]  <= PW'(w_d[0]) * PW'(r2_p);
            r3_p[6]  <= PW'(r2_a0) * PW'(r2_n);
            r3_p[7]  <= PW'(r2_d0) * PW'(r2_q);
            r3_p[8]  <= PW'(w_d[0]) * PW'(r2_r);
            r3_p[9]  <= PW'(r2_a0) * PW'(r2_p);
            r3_p[10] <= PW'(r2_b0) * PW'(r2_r);
            r3_p[11] <= PW'(r2_d0) * PW'(r2_s);
        end
    end

    // determinants
    always_ff @(posedge i_clk) begin
        if (w_ce) begin
            r4_det <= SW'(r3_p[0]) + SW'(r3_p[1]) + SW'(r3_p[2]);
            r4_e1  <= SW'(r3_p[3]) - SW'(r3_p[4]) - SW'(r3_p[5]);
            r4_e2  <= SW'(r3_p[6]) + SW'(r3_p[7]) + SW'(r3_p[8]);
            r4_e3  <= SW'(r3_p[9]) - SW'(r3_p[10]) + SW'(r3_p[11]);
        end
    end

    // make the determinant non-negative
    always_ff @(posedge i_clk) begin
        if (w_ce) begin
            if (r4_det[SW-1]) begin
                r5_det <= -r4_det;
                r5_e1  <= -r4_e1;
                r5_e2  <= -r4_e2;
                r5_e3  <= -r4_e3;
            end else begin
                r5_det <= r4_det;
                r5_e1  <= r4_e1;
                r5_e2  <= r4_e2;
                r5_e3  <= r4_e3;
            end
        end
    end

    // barycentric and sign tests
    always_ff @(posedge i_clk) begin
        if (w_ce) begin
            r6_ok  <= (r5_det != '0) && !r5_e1[SW-1] && !r5_e2[SW-1] && !r5_e3[SW-1]
                      && ((SW+1)'(r5_e1) + (SW+1)'(r5_e2) <= (SW+1)'(r5_det));
            r6_det <= r5_det[AW-1:0];
            r6_e3  <= r5_e3[AW-1:0];
        end
    end

    rti_div #(
        .DW (AW)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ce    (w_ce),
        .i_valid (r_v6),
        .i_ok    (r6_ok),
        .i_num   (r6_e3),
        .i_den   (r6_det),
        .o_valid (w_div_vld),
        .o_ok    (w_div_ok),
        .o_big   (w_div_big),
        .o_quo   (w_div_quo)
    );

    // epsilon test and saturation of t
    always_ff @(posedge i_clk) begin
        if (w_ce) begin
            r7_hit  <= w_div_ok && (w_div_big || (w_div_quo >= QUO_BITS'(r_eps)));
            r7_tout <= (w_div_big || (TW'(w_div_quo) > TW'(RMAX))) ? RMAX : R'(w_div_quo);
        end
    end

    // direction times t
    always_ff @(posedge i_clk) begin
        if (w_ce) begin
            r8_hit  <= r7_hit;
            r8_tout <= r7_tout;
            for (int j = 0; j < 3; j++) begin
                r8_prod[j] <= PRW'(r_dir[j]) * PRW'($signed({1'b0, r7_tout}));
            end
        end
    end

    // hit point, saturated
    always_comb begin
        logic signed [SUMW-1:0] sum;
        for (int j = 0; j < 3; j++) begin
            sum = (SUMW'(r_orig[j]) <<< 8) + SUMW'(r8_prod[j] >>> 8);
            if (sum > SMAX) begin
                n_pt[j] = R'(SMAX);
            end else if (sum < SMIN) begin
                n_pt[j] = R'(SMIN);
            end else begin
                n_pt[j] = R'(sum);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ce) begin
            r_hit <= r8_hit;
            r_t   <= r8_hit ? r8_tout : '0;
            for (int j = 0; j < 3; j++) begin
                r_pt[j] <= r8_hit ? n_pt[j] : '0;
            end
        end
    end

    assign o_m_tvalid = r_vo;
    assign o_m_tdata  = OUTW'({r_pt[2], r_pt[1], r_pt[0], r_t, r_hit});

    `RTI_ASSERT_IMPL(a_miss_zero, r_vo && !r_hit, (r_t == '0) && (r_pt[0] == '0) && (r_pt[1] == '0) && (r_pt[2] == '0))
    `RTI_ASSERT_IMPL(a_hit_t_nonneg, r_vo && r_hit, !r_t[R-1])
    `RTI_ASSERT_NEXT(a_reject_miss, w_ce && w_div_vld && !w_div_ok, !r7_hit)

endmodule

>>> sim/testbench.sv
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import rti_pkg::*;

    localparam int CB = 16;
    localparam int RB = 32;
    localparam int SW = ((9*CB+7)/8)*8;
    localparam int MW = ((1+4*RB+7)/8)*8;
    localparam int LATENCY = 58;

    typedef struct packed {
        logic [31:0] pz;
        logic [31:0] py;
        logic [31:0] px;
        logic [31:0] t;
        logic        hit;
    } t_hit_rec;

    logic i_clk = 0;
    logic i_rst_n = 0;
    logic i_cfg_we = 0;
    logic [CFG_IDX_BITS-1:0] i_cfg_idx = '0;
    logic [30:0] i_cfg_wdata = '0;
    logic i_s_tvalid = 0;
    logic o_s_tready;
    logic [SW-1:0] i_s_tdata = '0;
    logic o_m_tvalid;
    logic i_m_tready = 0;
    logic [MW-1:0] o_m_tdata;

    ray_triangle_intersection uut (.*);

    always begin
        #2 i_clk = 1;
        #2 i_clk = 0;
    end

    logic signed [15:0] ray_org [3];
    logic signed [15:0] ray_dir [3];
    logic [30:0] min_dist;
    t_hit_rec hits_pending [$];
    int mismatches = 0;
    bit sink_stall_on = 1;

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(4, 30);
    endfunction

    function automatic t_hit_rec predict_hit(logic signed [15:0] vt [9]);
        t_hit_rec res;
        longint a, b, c, d, e, f, g, h, ii, j, k, l, m, n, p, q, s, r;
        longint det, e1, e2, e3, rmax, rmin, pr, part;
        longint unsigned q0, rem, frac, tx, tout, dm, pm;
        bit big;
        res = '0;
        rmax = 64'sd2147483647;
        rmin = -rmax - 1;
        a = vt[0] - vt[3]; b = vt[0] - vt[6]; c = ray_dir[0]; d = vt[0] - ray_org[0];
        e = vt[1] - vt[4]; f = vt[1] - vt[7]; g = ray_dir[1]; h = vt[1] - ray_org[1];
        ii = vt[2] - vt[5]; j = vt[2] - vt[8]; k = ray_dir[2]; l = vt[2] - ray_org[2];
        m = f*k - g*j; n = h*k - g*l; p = f*l - h*j;
        q = g*ii - e*k; s = e*j - f*ii; r = e*l - h*ii;
        det = a*m + b*q + c*s;
        e1 = d*m - b*n - c*p;
        e2 = a*n + d*q + c*r;
        e3 = a*p - b*r + d*s;
        if (det < 0) begin
            det = -det; e1 = -e1; e2 = -e2; e3 = -e3;
        end
        if (det <= 0 || e1 < 0 || e2 < 0 || (e1 + e2) > det || e3 < 0) return res;
        q0 = longint'(e3) / longint'(det);
        rem = longint'(e3) % longint'(det);
        frac = 0;
        for (int i = 0; i < 16; i++) begin
            rem = rem << 1;
            frac = frac << 1;
            if (rem >= det) begin
                rem -= det;
                frac |= 1;
            end
        end
        big = q0 >= 64'h1_0000_0000;
        tx = big ? 0 : ((q0 << 16) | frac);
        if (!big && tx < min_dist) return res;
        tout = (big || tx > rmax) ? rmax : tx;
        res.hit = 1;
        res.t = tout[31:0];
        for (int i = 0; i < 3; i++) begin
            dm = ray_dir[i] < 0 ? -longint'(ray_dir[i]) : ray_dir[i];
            if (dm != 0 && tout > (64'h4000_0000_0000_0000 / dm)) begin
                pr = ray_dir[i] > 0 ? rmax : rmin;
            end else begin
                pm = dm * tout;
                part = ray_dir[i] < 0 ? -longint'((pm + 255) >> 8) : longint'(pm >> 8);
                pr = longint'(ray_org[i]) * 256 + part;
                if (pr > rmax) pr = rmax;
                if (pr < rmin) pr = rmin;
            end
            if (i == 0) res.px = pr[31:0];
            else if (i == 1) res.py = pr[31:0];
            else res.pz = pr[31:0];
        end
        return res;
    endfunction

    task automatic write_reg(t_cfg_idx idx, logic [30:0] val);
        @(posedge i_clk);
        i_cfg_we <= 1;
        i_cfg_idx <= idx;
        i_cfg_wdata <= val;
        if (idx == CFG_EPSILON) min_dist = val;
        else if (idx <= CFG_ORIGIN_Z) ray_org[idx] = val[15:0];
        else ray_dir[idx - CFG_DIR_X] = val[15:0];
        @(posedge i_clk);
        i_cfg_we <= 0;
    endtask

    task automatic drain();
        int guard;
        guard = 0;
        i_s_tvalid <= 0;
        while (hits_pending.size() != 0 && guard < 100000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (LATENCY + 10) @(posedge i_clk);
    endtask

    task automatic set_ray(logic [15:0] ox, oy, oz, dx, dy, dz, logic [30:0] eps);
        drain();
        write_reg(CFG_ORIGIN_X, {15'b0, ox});
        write_reg(CFG_ORIGIN_Y, {15'b0, oy});
        write_reg(CFG_ORIGIN_Z, {15'b0, oz});
        write_reg(CFG_DIR_X, {15'b0, dx});
        write_reg(CFG_DIR_Y, {15'b0, dy});
        write_reg(CFG_DIR_Z, {15'b0, dz});
        write_reg(CFG_EPSILON, eps);
    endtask

    task automatic send_tri(logic signed [15:0] vt [9]);
        logic [SW-1:0] pk;
        int g;
        pk = '0;
        for (int i = 0; i < 9; i++) pk[i*16 +: 16] = vt[i];
        g = gap_len();
        if (g > 0) begin
            i_s_tvalid <= 0;
            repeat (g) @(posedge i_clk);
        end
        i_s_tvalid <= 1;
        i_s_tdata <= pk;
        hits_pending = {hits_pending, predict_hit(vt)};
        do @(posedge i_clk); while (!o_s_tready);
    endtask

    always @(posedge i_clk) begin
        t_hit_rec got, want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got = o_m_tdata[128:0];
            if (hits_pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result beat %h", got);
            end else begin
                want = hits_pending.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch exp hit=%b t=%h p=%h %h %h got hit=%b t=%h p=%h %h %h",
                                 want.hit, want.t, want.px, want.py, want.pz,
                                 got.hit, got.t, got.px, got.py, got.pz);
                end
            end
        end
        i_m_tready <= sink_stall_on ? (gap_len() == 0) || ($urandom_range(0, 1) == 1) : 1'b1;
    end

    function automatic logic signed [15:0] rnd_coord(int mode);
        if (mode == 0) return 16'($urandom);
        return $signed(16'($urandom_range(0, 2047))) - 16'sd1024;
    endfunction

    // triangle around the ray: random point on the ray plus spread vertices
    task automatic send_aimed(int spread);
        logic signed [15:0] vt [9];
        int tt;
        tt = $urandom_range(0, 40);
        for (int ax = 0; ax < 3; ax++) begin
            int cx;
            cx = ray_org[ax] + (ray_dir[ax] * tt) / 4;
            for (int v = 0; v < 3; v++)
                vt[v*3+ax] = 16'(cx + $signed($urandom_range(0, 2*spread)) - spread);
        end
        send_tri(vt);
    endtask

    task automatic test_directed();
        logic signed [15:0] vt [9];
        logic signed [15:0] base [9];
        base = '{-256, -256, 1024, 512, -256, 1024, -256, 512, 1024};
        send_tri(base);
        vt = '{0, 0, 1024, 0, 0, 1024, 0, 0, 1024};
        send_tri(vt);
        vt = '{-256, 0, 0, 512, 0, 0, -256, 0, 512};
        send_tri(vt);
        vt = '{-256, -256, -1024, 512, -256, -1024, -256, 512, -1024};
        send_tri(vt);
        vt = '{0, 0, 1024, 512, 0, 1024, 0, 512, 1024};
        send_tri(vt);
        vt = '{512, 512, 1024, 512, -256, 1024, -256, 512, 1024};
        send_tri(vt);
        vt = '{0, 0, 0, 512, 0, 0, 0, 512, 0};
        send_tri(vt);
        for (int i = 0; i < 9; i++) vt[i] = (i % 2) ? 16'sh7fff : -16'sh8000;
        send_tri(vt);
        for (int i = 0; i < 9; i++) vt[i] = 16'sh7fff;
        send_tri(vt);
        vt = '{-32768, -32768, 32767, 32767, -32768, 32767, -32768, 32767, 32767};
        send_tri(vt);
        set_ray(16'h8000, 16'h8000, 16'h8000, 16'h7fff, 16'h7fff, 16'h7fff, 31'd0);
        vt = '{32767, -32768, -32768, -32768, 32767, -32768, -32768, -32768, 32767};
        send_tri(vt);
        vt = '{-32767, -32768, -32768, -32768, -32767, -32768, -32768, -32768, -32767};
        send_tri(vt);
        set_ray(16'h7fff, 16'h7fff, 16'h7fff, 16'h8000, 16'h8000, 16'h0001, 31'h7fffffff);
        send_tri(base);
        vt = '{-32768, -32768, 0, 32767, -32768, 0, -32768, 32767, 0};
        send_tri(vt);
        set_ray(0, 0, 0, 0, 0, 1, 31'd0);
        vt = '{-32768, -32768, 32767, 32767, -32768, 32767, -32768, 32767, 32767};
        send_tri(vt);
        send_tri(base);
    endtask

    task automatic test_random_rays();
        logic signed [15:0] vt [9];
        for (int ph = 0; ph < 6; ph++) begin
            int md;
            md = ph % 2;
            set_ray($urandom_range(0, 1) ? 16'($urandom) : 16'($urandom_range(0, 511) - 256),
                    16'($urandom_range(0, 511) - 256), 16'($urandom_range(0, 511) - 256),
                    md ? 16'($urandom) : 16'($urandom_range(0, 511) - 256),
                    16'($urandom_range(0, 511) - 256), 16'($urandom_range(0, 511) - 256),
                    (ph == 5) ? 31'($urandom) : 31'($urandom_range(0, 3000)));
            for (int n = 0; n < 240; n++) begin
                if (n == 120) drain();
                if ($urandom_range(0, 3) != 0) begin
                    send_aimed($urandom_range(0, 1) ? 64 : 2000);
                end else begin
                    for (int i = 0; i < 9; i++) vt[i] = rnd_coord($urandom_range(0, 1));
                    send_tri(vt);
                end
            end
        end
    endtask

    task automatic test_no_stall();
        set_ray(0, 0, 0, 16'd256, 16'd128, 16'd64, 31'd66);
        sink_stall_on = 0;
        for (int n = 0; n < 60; n++) send_aimed(128);
        drain();
        sink_stall_on = 1;
    endtask

    initial begin
        ray_org = '{0, 0, 0};
        ray_dir = '{0, 0, 256};
        min_dist = 31'(EPS_RESET);
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1;
        test_directed();
        test_random_rays();
        test_no_stall();
        drain();
        if (mismatches == 0 && hits_pending.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("end of test: mismatches");
        $finish;
    end
endmodule
